// File: hdl/eqsg_pkg.sv
// Shared types and constants for the ellipse quadrant span generator.
package eqsg_pkg;

    // Corner codes carried on the request tuser
    localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd0;
    localparam logic [1:0] CORNER_TOP_LEFT     = 2'd1;
    localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd2;
    localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd3;

    localparam int CORNER_W   = 2;
    localparam int RAD_W      = 6;   // radius field width
    localparam int SQ_W       = 12;  // squared radius
    localparam int PROD_W     = 18;  // a^2 * b
    localparam int S_W        = 26;  // decision variable and its increments
    localparam int P_W        = 20;  // b^2*x and a^2*y loop-test terms
    localparam int CNT_W      = 7;   // column step, holds up to 64
    localparam int MIN_RADIUS = 2;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_MUL,
        BK_INIT,
        BK_RUN
    } back_state_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: hdl/eqsg_queue.sv
// Two-entry request queue between the front and back ends.
module eqsg_queue #(
    parameter int WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rd_data,
    output eqsg_pkg::queue_status_t status
);
    import eqsg_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    // Report fill state
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/eqsg_front.sv
// Front end: accepts requests, clamps radii, drops empty ones, packs the queue word.
module eqsg_front #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 12,
    parameter int QW         = 2 * COORD_BITS + 2 * 6 + 2,
    parameter int IN_W       = ((2 * COORD_BITS + 12 + 7) / 8) * 8
) (
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_W-1:0]                      s_tdata,
    input  logic [eqsg_pkg::CORNER_W-1:0]        s_tuser,
    output logic                                 push,
    output logic [QW-1:0]                        push_data,
    input  eqsg_pkg::queue_status_t              q_status
);
    import eqsg_pkg::*;

    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [RAD_W-1:0]      rx_raw, ry_raw, rx_c, ry_c;
    logic                  top, left, small_radius;

    // Unpack request fields
    assign cx     = s_tdata[COORD_BITS-1:0];
    assign cy     = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign rx_raw = s_tdata[2*COORD_BITS+RAD_W-1:2*COORD_BITS];
    assign ry_raw = s_tdata[2*COORD_BITS+2*RAD_W-1:2*COORD_BITS+RAD_W];

    // Saturate radii and classify the corner
    assign rx_c = (rx_raw > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rx_raw;
    assign ry_c = (ry_raw > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : ry_raw;
    assign top  = (s_tuser == CORNER_TOP_RIGHT) || (s_tuser == CORNER_TOP_LEFT);
    assign left = (s_tuser == CORNER_TOP_LEFT) || (s_tuser == CORNER_BOTTOM_LEFT);
    assign small_radius = (rx_c < RAD_W'(MIN_RADIUS)) || (ry_c < RAD_W'(MIN_RADIUS));

    // Accept while the queue has room; drop requests that make no span
    assign s_tready  = ~q_status.full;
    assign push      = s_tvalid & s_tready & ~small_radius;
    assign push_data = {cy, cx, ry_c, rx_c, left, top};

endmodule

// File: hdl/eqsg_back.sv
// Back end: sets up midpoint terms, steps region one, one span per cycle unless stalled.
module eqsg_back #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 12,
    parameter int QW         = 2 * COORD_BITS + 2 * 6 + 2,
    parameter int OUT_W      = ((3 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [QW-1:0]            q_data,
    input  eqsg_pkg::queue_status_t  q_status,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tlast
);
    import eqsg_pkg::*;

    localparam int OW        = COORD_BITS + 1;
    localparam int MAX_SPANS = MAX_RADIUS + 1;
    localparam int PAD_W     = OUT_W - 3 * OW;

    back_state_t state_reg, state_next;

    // Request fields
    logic                  top_reg, top_next;
    logic                  left_reg, left_next;
    logic [RAD_W-1:0]      a_reg, a_next;
    logic [RAD_W-1:0]      b_reg, b_next;
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;

    // Set-up terms
    logic [SQ_W-1:0]       a2_reg, a2_next;
    logic [SQ_W-1:0]       b2_reg, b2_next;
    logic [PROD_W-1:0]     a2b_reg, a2b_next;

    // Loop state
    logic [CNT_W-1:0]      x_reg, x_next;
    logic [RAD_W-1:0]      y_reg, y_next;
    logic signed [S_W-1:0] s_reg, s_next;
    logic signed [S_W-1:0] dy_reg, dy_next;
    logic signed [S_W-1:0] dx_reg, dx_next;
    logic signed [P_W-1:0] b2x_reg, b2x_next;
    logic signed [P_W-1:0] a2y_reg, a2y_next;

    // Output register
    logic                  valid_reg, valid_next;
    logic                  last_reg, last_next;
    logic [OW-1:0]         row_reg, row_next;
    logic [OW-1:0]         lft_reg, lft_next;
    logic [OW-1:0]         rgt_reg, rgt_next;

    // Widened copies of the set-up terms
    logic signed [S_W-1:0] a2_s, b2_s, a2b_s;
    logic signed [P_W-1:0] a2_p, b2_p;

    // Step datapath
    logic                  s_ge;
    logic signed [S_W-1:0] s1;
    logic                  more;
    logic [CNT_W-1:0]      x1;
    logic signed [P_W-1:0] b2x1, a2y1;
    logic                  out_free;
    logic [OW-1:0]         cx_e, cy_e, x_e, y_e;

    assign a2_s  = signed'(S_W'(a2_reg));
    assign b2_s  = signed'(S_W'(b2_reg));
    assign a2b_s = signed'(S_W'(a2b_reg));
    assign a2_p  = signed'(P_W'(a2_reg));
    assign b2_p  = signed'(P_W'(b2_reg));

    // Next loop-test terms and the decision on the error sign
    assign s_ge = ~s_reg[S_W-1];
    assign s1   = s_ge ? (s_reg + dy_reg) : s_reg;
    assign x1   = x_reg + CNT_W'(1);
    assign b2x1 = b2x_reg + b2_p;
    assign a2y1 = s_ge ? (a2y_reg - a2_p) : a2y_reg;
    assign more = (b2x1 <= a2y1) && (x1 < CNT_W'(MAX_SPANS));

    // Span coordinates at the current step
    assign cx_e = {cx_reg[COORD_BITS-1], cx_reg};
    assign cy_e = {cy_reg[COORD_BITS-1], cy_reg};
    assign x_e  = {{(OW-CNT_W){1'b0}}, x_reg};
    assign y_e  = {{(OW-RAD_W){1'b0}}, y_reg};

    assign out_free = ~valid_reg | m_tready;

    // Sequence set-up and stepping
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        top_next   = top_reg;
        left_next  = left_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        a2b_next   = a2b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        s_next     = s_reg;
        dy_next    = dy_reg;
        dx_next    = dx_reg;
        b2x_next   = b2x_reg;
        a2y_next   = a2y_reg;
        valid_next = valid_reg & ~m_tready;
        last_next  = last_reg;
        row_next   = row_reg;
        lft_next   = lft_reg;
        rgt_next   = rgt_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                // Take the next queued request
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    top_next   = q_data[0];
                    left_next  = q_data[1];
                    a_next     = q_data[RAD_W+1:2];
                    b_next     = q_data[2*RAD_W+1:RAD_W+2];
                    cx_next    = q_data[2*RAD_W+COORD_BITS+1:2*RAD_W+2];
                    cy_next    = q_data[2*RAD_W+2*COORD_BITS+1:2*RAD_W+COORD_BITS+2];
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                a2_next    = SQ_W'(a_reg) * SQ_W'(a_reg);
                b2_next    = SQ_W'(b_reg) * SQ_W'(b_reg);
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                a2b_next   = PROD_W'(a2_reg) * PROD_W'(b_reg);
                state_next = BK_INIT;
            end
            BK_INIT:
            begin
                // Start at the top of the quadrant
                s_next     = (b2_s <<< 1) + a2_s - (a2b_s <<< 1);
                dy_next    = (a2_s <<< 2) - (a2b_s <<< 2);
                dx_next    = (b2_s <<< 2) + (b2_s <<< 1);
                b2x_next   = '0;
                a2y_next   = signed'(P_W'(a2b_reg));
                x_next     = '0;
                y_next     = b_reg;
                state_next = BK_RUN;
            end
            BK_RUN:
            begin
                // Emit one span and advance one column
                if (out_free)
                begin
                    valid_next = 1'b1;
                    last_next  = ~more;
                    row_next   = top_reg ? (cy_e - y_e) : (cy_e + y_e);
                    lft_next   = left_reg ? (cx_e - x_e) : cx_e;
                    rgt_next   = left_reg ? cx_e : (cx_e + x_e);
                    s_next     = s1 + dx_reg;
                    dx_next    = dx_reg + (b2_s <<< 2);
                    dy_next    = s_ge ? (dy_reg + (a2_s <<< 2)) : dy_reg;
                    y_next     = s_ge ? (y_reg - RAD_W'(1)) : y_reg;
                    a2y_next   = a2y1;
                    b2x_next   = b2x1;
                    x_next     = x1;
                    if (!more)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        left_reg <= left_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        a2b_reg  <= a2b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        s_reg    <= s_next;
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        b2x_reg  <= b2x_next;
        a2y_reg  <= a2y_next;
        last_reg <= last_next;
        row_reg  <= row_next;
        lft_reg  <= lft_next;
        rgt_reg  <= rgt_next;
    end

    // Drive the result word
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, rgt_reg, lft_reg, row_reg};

endmodule

// File: hdl/ellipse_quadrant_span_generator_top.sv
// Top level of the ellipse quadrant span generator.
//
//  channel   dir  tdata (low bit up)                         tuser    tlast
//  s_*       in   center_x, center_y, radius_x, radius_y    corner   -
//  m_*       out  span_row, span_left, span_right            -        last_span
//
// A request with both radii of at least 2 goes through the set-up steps pop,
// squares, a^2*b and initial error, then yields one span per cycle while the
// output is not stalled, N spans in all with N at most MAX_RADIUS + 1.
// A request with a radius below 2 is accepted and gives no word.
// Reset clears the queue, the sequencer and the output valid; a stalled output
// word holds the stepper, while the two-entry queue accepts requests until full.
module ellipse_quadrant_span_generator_top #(
    parameter int MAX_RADIUS = 63,
    parameter int COORD_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // center_x, center_y, radius_x, radius_y, zero pad
    input  logic [((2*COORD_BITS+12+7)/8)*8-1:0] s_tdata,
    // corner
    input  logic [eqsg_pkg::CORNER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // span_row, span_left, span_right, zero pad
    output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
    output logic                           m_tlast
);
    import eqsg_pkg::*;

    localparam int QW    = 2 * COORD_BITS + 2 * RAD_W + 2;
    localparam int IN_W  = ((2 * COORD_BITS + 12 + 7) / 8) * 8;
    localparam int OUT_W = ((3 * (COORD_BITS + 1) + 7) / 8) * 8;

    logic          push, pop;
    logic [QW-1:0] push_data, q_data;
    queue_status_t q_status;

    eqsg_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS),
        .QW         (QW),
        .IN_W       (IN_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_data (push_data),
        .q_status  (q_status)
    );

    eqsg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    eqsg_back #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS),
        .QW         (QW),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
